FILE: design/sccr_pkg.sv
`timescale 1ns / 1ps

package sccr_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 16;
    localparam int VEC_W         = 27;
    localparam int ACC_W         = 34;

    typedef enum logic [7:0] {
        REG_AZIMUTH_CELLS       = 8'd0,
        REG_POLAR_CELLS         = 8'd1,
        REG_MERIDIAN_LINE_WIDTH = 8'd2,
        REG_PARALLEL_LINE_WIDTH = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REGION_EVEN    = 2'd0,
        REGION_ODD     = 2'd1,
        REGION_OUTLINE = 2'd2
    } region_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_entry(input logic [4:0] i);
        logic [ACC_W-1:0] r;
        case (i)
            5'd0:    r = ACC_W'(536870912);
            5'd1:    r = ACC_W'(316933406);
            5'd2:    r = ACC_W'(167458907);
            5'd3:    r = ACC_W'(85004756);
            5'd4:    r = ACC_W'(42667331);
            5'd5:    r = ACC_W'(21354465);
            5'd6:    r = ACC_W'(10680862);
            5'd7:    r = ACC_W'(5340245);
            5'd8:    r = ACC_W'(2670163);
            5'd9:    r = ACC_W'(1335087);
            5'd10:   r = ACC_W'(667544);
            5'd11:   r = ACC_W'(333772);
            5'd12:   r = ACC_W'(166886);
            5'd13:   r = ACC_W'(83443);
            5'd14:   r = ACC_W'(41722);
            5'd15:   r = ACC_W'(20861);
            5'd16:   r = ACC_W'(10430);
            5'd17:   r = ACC_W'(5215);
            5'd18:   r = ACC_W'(2608);
            5'd19:   r = ACC_W'(1304);
            5'd20:   r = ACC_W'(652);
            5'd21:   r = ACC_W'(326);
            5'd22:   r = ACC_W'(163);
            5'd23:   r = ACC_W'(81);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/sphere_checker_region_classifier_unit.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; the whole pipeline advances together and
//   freezes only while a result sits in the output register under out_stall.
// Cost per stage: one square-root digit or one CORDIC rotation of both angles.
// Reset: rst_n asynchronous, active low; clears valid bits and loads register defaults.
module sphere_checker_region_classifier_unit #(
    parameter int ANGLE_BITS    = sccr_pkg::ANGLE_BITS,
    parameter int CORDIC_STAGES = sccr_pkg::CORDIC_STAGES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] hit_x,
    input  logic signed [15:0] hit_y,
    input  logic signed [15:0] hit_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         region,
    output logic [7:0]         azimuth_index,
    output logic [7:0]         polar_index
);

    localparam int AB  = ANGLE_BITS;
    localparam int N   = CORDIC_STAGES;
    localparam int SQ  = sccr_pkg::SQRT_STEPS;
    localparam int VW  = sccr_pkg::VEC_W;
    localparam int AW  = sccr_pkg::ACC_W;
    localparam int NW  = AB + 18;   // width of the exact edge compare

    // ---------------- configuration registers ----------------
    logic [7:0]  azimuth_cells_reg, polar_cells_reg;
    logic [15:0] meridian_width_reg, parallel_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            azimuth_cells_reg  <= 8'd16;
            polar_cells_reg    <= 8'd8;
            meridian_width_reg <= '0;
            parallel_width_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sccr_pkg::REG_AZIMUTH_CELLS:       azimuth_cells_reg  <= cfg_data[7:0];
                sccr_pkg::REG_POLAR_CELLS:         polar_cells_reg    <= cfg_data[7:0];
                sccr_pkg::REG_MERIDIAN_LINE_WIDTH: meridian_width_reg <= cfg_data;
                sccr_pkg::REG_PARALLEL_LINE_WIDTH: parallel_width_reg <= cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // a zero cell count acts as one
    logic [7:0] ac_eff, pc_eff;
    assign ac_eff = (azimuth_cells_reg == 8'd0) ? 8'd1 : azimuth_cells_reg;
    assign pc_eff = (polar_cells_reg == 8'd0) ? 8'd1 : polar_cells_reg;

    // ---------------- global advance ----------------
    // Every stage moves when the output register is free or being taken.
    logic out_valid_reg;
    logic adv;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ---------------- stage A: capture ----------------
    logic               a_valid_reg;
    logic signed [15:0] a_x_reg, a_y_reg, a_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg <= hit_x;
            a_y_reg <= hit_y;
            a_z_reg <= hit_z;
        end
    end

    // ---------------- stage B: 1 - y*y in Q2.30 ----------------
    // y*y never exceeds 2^30, so 1 - y*y never goes below zero and needs no clamp.
    logic signed [31:0] ysq;
    assign ysq = 32'(a_y_reg * a_y_reg);

    logic               sq_valid_reg [0:SQ];
    logic [31:0]        sq_v_reg     [0:SQ];
    logic [31:0]        sq_r_reg     [0:SQ];
    logic signed [15:0] sq_x_reg     [0:SQ];
    logic signed [15:0] sq_y_reg     [0:SQ];
    logic signed [15:0] sq_z_reg     [0:SQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0] <= 32'd1073741824 - 32'(ysq);
            sq_r_reg[0] <= '0;
            sq_x_reg[0] <= a_x_reg;
            sq_y_reg[0] <= a_y_reg;
            sq_z_reg[0] <= a_z_reg;
        end
    end

    // ---------------- square root: one digit per stage ----------------
    genvar k;
    generate
        for (k = 0; k < SQ; k++)
        begin : g_sqrt
            logic [31:0] bit_w, trial;
            logic [31:0] v_next, r_next;
            assign bit_w = 32'd1 << (30 - 2 * k);
            assign trial = sq_r_reg[k] + bit_w;

            always_comb
            begin
                if (sq_v_reg[k] >= trial)
                begin
                    v_next = sq_v_reg[k] - trial;
                    r_next = (sq_r_reg[k] >> 1) + bit_w;
                end
                else
                begin
                    v_next = sq_v_reg[k];
                    r_next = sq_r_reg[k] >> 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_valid_reg[k+1] <= 1'b0;
                else if (adv)
                    sq_valid_reg[k+1] <= sq_valid_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sq_v_reg[k+1] <= v_next;
                    sq_r_reg[k+1] <= r_next;
                    sq_x_reg[k+1] <= sq_x_reg[k];
                    sq_y_reg[k+1] <= sq_y_reg[k];
                    sq_z_reg[k+1] <= sq_z_reg[k];
                end
            end
        end
    endgenerate

    // ---------------- stage C: CORDIC setup ----------------
    // Operands are scaled by 256; a vector in the left half-plane is flipped
    // and starts at a half turn.
    logic                 cd_valid_reg [0:N];
    logic signed [VW-1:0] cp_x_reg [0:N], cp_y_reg [0:N];
    logic signed [VW-1:0] ct_x_reg [0:N], ct_y_reg [0:N];
    logic signed [AW-1:0] cp_acc_reg [0:N], ct_acc_reg [0:N];
    logic                 cp_zero_reg [0:N], ct_zero_reg [0:N];

    logic signed [VW-1:0] p_vx, p_vy, t_vx, t_vy;
    assign p_vx = VW'(sq_z_reg[SQ]) <<< 8;
    assign p_vy = VW'(sq_x_reg[SQ]) <<< 8;
    assign t_vx = VW'(sq_y_reg[SQ]) <<< 8;
    assign t_vy = $signed({{(VW-24){1'b0}}, sq_r_reg[SQ][15:0], 8'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_valid_reg[0] <= 1'b0;
        else if (adv)
            cd_valid_reg[0] <= sq_valid_reg[SQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp_zero_reg[0] <= (p_vx == '0) && (p_vy == '0);
            ct_zero_reg[0] <= (t_vx == '0) && (t_vy == '0);
            if (p_vx < 0)
            begin
                cp_x_reg[0]   <= -p_vx;
                cp_y_reg[0]   <= -p_vy;
                cp_acc_reg[0] <= AW'(64'sd2147483648);
            end
            else
            begin
                cp_x_reg[0]   <= p_vx;
                cp_y_reg[0]   <= p_vy;
                cp_acc_reg[0] <= '0;
            end
            if (t_vx < 0)
            begin
                ct_x_reg[0]   <= -t_vx;
                ct_y_reg[0]   <= -t_vy;
                ct_acc_reg[0] <= AW'(64'sd2147483648);
            end
            else
            begin
                ct_x_reg[0]   <= t_vx;
                ct_y_reg[0]   <= t_vy;
                ct_acc_reg[0] <= '0;
            end
        end
    end

    // ---------------- CORDIC rotations: one per stage, both angles ----------------
    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cordic
            logic signed [AW-1:0] atan_w;
            assign atan_w = $signed(sccr_pkg::atan_entry(5'(i)));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    cd_valid_reg[i+1] <= 1'b0;
                else if (adv)
                    cd_valid_reg[i+1] <= cd_valid_reg[i];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cp_zero_reg[i+1] <= cp_zero_reg[i];
                    ct_zero_reg[i+1] <= ct_zero_reg[i];
                    if (cp_y_reg[i] >= 0)
                    begin
                        cp_x_reg[i+1]   <= cp_x_reg[i] + (cp_y_reg[i] >>> i);
                        cp_y_reg[i+1]   <= cp_y_reg[i] - (cp_x_reg[i] >>> i);
                        cp_acc_reg[i+1] <= cp_acc_reg[i] + atan_w;
                    end
                    else
                    begin
                        cp_x_reg[i+1]   <= cp_x_reg[i] - (cp_y_reg[i] >>> i);
                        cp_y_reg[i+1]   <= cp_y_reg[i] + (cp_x_reg[i] >>> i);
                        cp_acc_reg[i+1] <= cp_acc_reg[i] - atan_w;
                    end
                    if (ct_y_reg[i] >= 0)
                    begin
                        ct_x_reg[i+1]   <= ct_x_reg[i] + (ct_y_reg[i] >>> i);
                        ct_y_reg[i+1]   <= ct_y_reg[i] - (ct_x_reg[i] >>> i);
                        ct_acc_reg[i+1] <= ct_acc_reg[i] + atan_w;
                    end
                    else
                    begin
                        ct_x_reg[i+1]   <= ct_x_reg[i] - (ct_y_reg[i] >>> i);
                        ct_y_reg[i+1]   <= ct_y_reg[i] + (ct_x_reg[i] >>> i);
                        ct_acc_reg[i+1] <= ct_acc_reg[i] - atan_w;
                    end
                end
            end
        end
    endgenerate

    // ---------------- stage D: angles and cell scaling ----------------
    logic signed [AW-1:0] phi_acc, th_acc, th_clamp;
    logic [AB-1:0]        phi;
    logic [AB:0]          theta;

    assign phi_acc = cp_zero_reg[N] ? '0 : cp_acc_reg[N];
    assign th_acc  = ct_zero_reg[N] ? '0 : ct_acc_reg[N];

    always_comb
    begin
        if (th_acc < 0)
            th_clamp = '0;
        else if (th_acc > AW'(64'sd2147483648))
            th_clamp = AW'(64'sd2147483648);
        else
            th_clamp = th_acc;
    end

    assign phi   = phi_acc[31:32-AB];
    assign theta = th_clamp[31:31-AB];

    logic          d_valid_reg;
    logic [AB+7:0] d_tp_reg;
    logic [AB+8:0] d_tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (adv)
            d_valid_reg <= cd_valid_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_tp_reg <= (AB+8)'(phi) * (AB+8)'(ac_eff);
            d_tt_reg <= (AB+9)'(theta) * (AB+9)'(pc_eff);
        end
    end

    // ---------------- stage E: indices, outlines, region ----------------
    logic [7:0]    ip, it;
    logic [8:0]    it_raw;
    logic [AB-1:0] fp, ft;

    assign ip     = d_tp_reg[AB+7:AB];
    assign fp     = d_tp_reg[AB-1:0];
    assign it_raw = d_tt_reg[AB+8:AB];

    // the south pole lands one past the last cell: saturate
    always_comb
    begin
        if (it_raw >= {1'b0, pc_eff})
        begin
            it = pc_eff - 8'd1;
            ft = '1;
        end
        else
        begin
            it = it_raw[7:0];
            ft = d_tt_reg[AB-1:0];
        end
    end

    logic [NW-1:0] f_p, f_t, w_p, w_t, one_w;
    logic          near_p, near_t;
    assign one_w  = NW'(1) << (AB + 17);
    assign f_p    = NW'(fp) << 17;
    assign f_t    = NW'(ft) << 17;
    assign w_p    = NW'(meridian_width_reg) << AB;
    assign w_t    = NW'(parallel_width_reg) << AB;
    assign near_p = (f_p < w_p) || (f_p > one_w - w_p);
    assign near_t = (f_t < w_t) || (f_t > one_w - w_t);

    logic [1:0] region_next;
    always_comb
    begin
        if (near_p || near_t)
            region_next = sccr_pkg::REGION_OUTLINE;
        else if (ip[0] ^ it[0])
            region_next = sccr_pkg::REGION_ODD;
        else
            region_next = sccr_pkg::REGION_EVEN;
    end

    logic [1:0] region_reg;
    logic [7:0] az_index_reg, pol_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            region_reg    <= region_next;
            az_index_reg  <= ip;
            pol_index_reg <= it;
        end
    end

    assign out_valid     = out_valid_reg;
    assign region        = region_reg;
    assign azimuth_index = az_index_reg;
    assign polar_index   = pol_index_reg;

    // ---------------- assertions ----------------
    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> region != 2'd3)
        else $error("region code out of range");

    a_polar_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(cfg_write)) |-> polar_index < pc_eff)
        else $error("polar index not saturated");

    a_azimuth_rng: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(cfg_write)) |-> azimuth_index < ac_eff)
        else $error("azimuth index past cell count");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(d_valid_reg) && $stable(d_tp_reg))
        else $error("pipeline moved during stall");

endmodule

FILE: sim/tb_sphere_checker_region_classifier_unit.sv
`timescale 1ns / 1ps

module tb_sphere_checker_region_classifier_unit;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } hit_t;

    typedef struct packed {
        logic [1:0] region;
        logic [7:0] az;
        logic [7:0] pol;
    } cell_t;

    localparam int LATENCY   = sccr_pkg::CORDIC_STAGES + 21;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [7:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] hit_x = '0, hit_y = '0, hit_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] region;
    logic [7:0] azimuth_index, polar_index;

    // shadow copy of the configuration registers
    logic [7:0]  az_cells = 8'd16;
    logic [7:0]  pol_cells = 8'd8;
    logic [15:0] mer_width = '0;
    logic [15:0] par_width = '0;

    hit_t  pending_hits[$];
    cell_t expected_cells[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    idle_cycles = 0;
    int    hold_off = 0;
    int    send_gap = 0;

    sphere_checker_region_classifier_unit uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int random_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = longint'($floor($sqrt(real'(v))));
        while (r * r > v)
            r--;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    // vectoring rotation; angle in 2^-32 turn
    function automatic longint vector_angle(longint vx, longint vy);
        longint acc, dx, dy;
        acc = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0)
        begin
            vx = -vx;
            vy = -vy;
            acc = 64'sd2147483648;
        end
        for (int i = 0; i < sccr_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            dx = shift_floor(vy, i);
            dy = shift_floor(vx, i);
            if (vy >= 0)
            begin
                vx += dx;
                vy -= dy;
                acc += longint'(sccr_pkg::atan_entry(5'(i)));
            end
            else
            begin
                vx -= dx;
                vy += dy;
                acc -= longint'(sccr_pkg::atan_entry(5'(i)));
            end
        end
        return acc;
    endfunction

    function automatic bit near_border(longint frac, longint width);
        longint f, w, one;
        f = frac << 17;
        w = width << sccr_pkg::ANGLE_BITS;
        one = longint'(1) << (sccr_pkg::ANGLE_BITS + 17);
        return (f < w) || (f > one - w);
    endfunction

    function automatic cell_t classify_hit(hit_t h);
        longint mask, a, rem, s, phi, theta, t, ip, it, fp, ft, ac, pc;
        cell_t c;
        mask = (longint'(1) << sccr_pkg::ANGLE_BITS) - 1;
        ac = (az_cells == 0) ? 1 : az_cells;
        pc = (pol_cells == 0) ? 1 : pol_cells;
        a = vector_angle(longint'(h.z) * 256, longint'(h.x) * 256);
        phi = (a & 64'hFFFF_FFFF) >> (32 - sccr_pkg::ANGLE_BITS);
        rem = 64'sd1073741824 - longint'(h.y) * longint'(h.y);
        if (rem < 0)
            rem = 0;
        s = root_floor(rem);
        a = vector_angle(longint'(h.y) * 256, s * 256);
        if (a < 0)
            a = 0;
        if (a > 64'sd2147483648)
            a = 64'sd2147483648;
        theta = a >> (31 - sccr_pkg::ANGLE_BITS);
        t = phi * ac;
        ip = t >> sccr_pkg::ANGLE_BITS;
        fp = t & mask;
        t = theta * pc;
        it = t >> sccr_pkg::ANGLE_BITS;
        ft = t & mask;
        // south pole: saturate index and fraction
        if (it >= pc)
        begin
            it = pc - 1;
            ft = mask;
        end
        if (near_border(fp, mer_width) || near_border(ft, par_width))
            c.region = sccr_pkg::REGION_OUTLINE;
        else
            c.region = ((ip + it) & 1) ? sccr_pkg::REGION_ODD : sccr_pkg::REGION_EVEN;
        c.az = ip[7:0];
        c.pol = it[7:0];
        return c;
    endfunction

    // Driver: offer queued hit points with random gaps; hold payload while stalled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_cells.push_back(classify_hit({hit_x, hit_y, hit_z}));
                void'(pending_hits.pop_front());
                send_gap = random_gap();
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_hits.size() > 0 && !(in_valid && !in_stall
                         && pending_hits.size() == 0))
                begin
                    in_valid <= 1'b1;
                    hit_x <= pending_hits[0].x;
                    hit_y <= pending_hits[0].y;
                    hit_z <= pending_hits[0].z;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        cell_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d %0d %0d",
                                 region, azimuth_index, polar_index);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (want !== {region, azimuth_index, polar_index})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp reg %0d az %0d pol %0d, got %0d %0d %0d",
                                     want.region, want.az, want.pol,
                                     region, azimuth_index, polar_index);
                    end
                end
            end
            // receiver stall: forced or occasional long hold-off, else short random gaps
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 40) == 0)
            begin
                hold_off = $urandom_range(10, 40);
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(sccr_pkg::cfg_reg_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sccr_pkg::REG_AZIMUTH_CELLS:       az_cells = val[7:0];
            sccr_pkg::REG_POLAR_CELLS:         pol_cells = val[7:0];
            sccr_pkg::REG_MERIDIAN_LINE_WIDTH: mer_width = val;
            sccr_pkg::REG_PARALLEL_LINE_WIDTH: par_width = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_hits.size() == 0 && !in_valid && expected_cells.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic hit_t sphere_point();
        hit_t h;
        real th, ph;
        th = real'($urandom) / 4294967296.0 * 3.14159265;
        ph = real'($urandom) / 4294967296.0 * 6.2831853;
        h.y = 16'(int'(32767.0 * $cos(th)));
        h.x = 16'(int'(32767.0 * $sin(th) * $sin(ph)));
        h.z = 16'(int'(32767.0 * $sin(th) * $cos(ph)));
        return h;
    endfunction

    task automatic queue_random(int n);
        hit_t h;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                h = {16'($urandom), 16'($urandom), 16'($urandom)};
            else
                h = sphere_point();
            pending_hits.push_back(h);
        end
    endtask

    initial
    begin
        hit_t directed[$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: poles, axes, zero vector, field extremes, off-sphere points
        directed = '{
            '{16'sd0, 16'sd32767, 16'sd0}, '{16'sd0, -16'sd32768, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0}, '{16'sd32767, 16'sd0, 16'sd0},
            '{-16'sd32768, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd32767},
            '{16'sd0, 16'sd0, -16'sd32768}, '{-16'sd1, 16'sd0, -16'sd32768},
            '{16'sd1, 16'sd0, -16'sd32768}, '{16'sd23170, 16'sd0, 16'sd23170},
            '{-16'sd23170, 16'sd0, -16'sd23170}, '{16'sd32767, 16'sd32767, 16'sd32767},
            '{-16'sd32768, -16'sd32768, -16'sd32768}, '{16'sd5, -16'sd3, 16'sd0},
            '{16'sd0, -16'sd32767, 16'sd1}, '{-16'sd21846, 16'sd16384, 16'sd12000}
        };
        foreach (directed[i])
            pending_hits.push_back(directed[i]);
        drain();

        // extremes of the registers, zero acting as one
        write_reg(sccr_pkg::REG_AZIMUTH_CELLS, 16'd255);
        write_reg(sccr_pkg::REG_POLAR_CELLS, 16'd255);
        write_reg(sccr_pkg::REG_MERIDIAN_LINE_WIDTH, 16'd6000);
        write_reg(sccr_pkg::REG_PARALLEL_LINE_WIDTH, 16'd65535);
        foreach (directed[i])
            pending_hits.push_back(directed[i]);
        queue_random(60);
        drain();

        write_reg(sccr_pkg::REG_AZIMUTH_CELLS, 16'd0);
        write_reg(sccr_pkg::REG_POLAR_CELLS, 16'd0);
        write_reg(sccr_pkg::REG_MERIDIAN_LINE_WIDTH, 16'd0);
        write_reg(sccr_pkg::REG_PARALLEL_LINE_WIDTH, 16'd3000);
        foreach (directed[i])
            pending_hits.push_back(directed[i]);
        queue_random(40);
        drain();

        // unknown register index write; every register is rewritten below before any check
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= 8'd7;
        cfg_data <= 16'hFFFF;
        @(posedge clk);
        cfg_write <= 1'b0;

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(sccr_pkg::REG_AZIMUTH_CELLS, 16'($urandom));
            write_reg(sccr_pkg::REG_POLAR_CELLS, 16'($urandom));
            write_reg(sccr_pkg::REG_MERIDIAN_LINE_WIDTH, 16'($urandom_range(0, 12000)));
            write_reg(sccr_pkg::REG_PARALLEL_LINE_WIDTH, 16'($urandom_range(0, 12000)));
            // once, stall the output long enough to back the pipeline up
            if (phase == 2)
                hold_off = 300;
            queue_random(55);
            drain();
        end

        write_reg(sccr_pkg::REG_AZIMUTH_CELLS, 16'd1);
        write_reg(sccr_pkg::REG_POLAR_CELLS, 16'd1);
        write_reg(sccr_pkg::REG_MERIDIAN_LINE_WIDTH, 16'd65535);
        write_reg(sccr_pkg::REG_PARALLEL_LINE_WIDTH, 16'd0);
        queue_random(20);
        drain();

        $display("Checked %0d classified hit points over several cell and line settings,",
                 results_seen);
        $display("including poles, zero vector, off-sphere points and a long output stall.");
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
